// ----- rtl/core/octave_gradient_noise_3d_macros.svh -----
// ----------------------------------------------------------------------------
// Octave gradient noise 3D - assertion macros
// Shared concurrent assertion wrappers, clocked on i_clk.
// ----------------------------------------------------------------------------
`ifndef OCTAVE_GRADIENT_NOISE_3D_MACROS_SVH
`define OCTAVE_GRADIENT_NOISE_3D_MACROS_SVH

// Checked only outside reset
`define OGNZ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked at every edge, reset included
`define OGNZ_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ----- rtl/core/ognz_pkg.sv -----
// ----------------------------------------------------------------------------
// ognz_pkg
// Types, constants and helper functions for the octave gradient noise block.
// ----------------------------------------------------------------------------
package ognz_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int DW         = FRAC_BITS + 10;   // working value, signed
    localparam int MBW        = 32;               // second multiplier operand
    localparam int PW         = DW + MBW;         // raw product
    localparam int AMPW       = 31;               // amplitude, unsigned Q.14
    localparam int PERSW      = 16;
    localparam int CNTW       = 4;
    localparam int COORDW     = 32;
    localparam int CELLW      = 8;
    localparam int HASHW      = 4;
    localparam int OUTW       = 16;
    localparam int IN_TDATA_W = 2 * CELLW + 3 * COORDW;
    localparam int AMP_SHIFT  = 14;

    typedef logic signed [DW-1:0] t_val;
    typedef logic signed [PW-1:0] t_prod;

    localparam t_val ONE_Q     = t_val'(64'sd1 << FRAC_BITS);
    localparam t_val TEN_Q     = t_val'(64'sd10 << FRAC_BITS);
    localparam t_val FIFTEEN_Q = t_val'(64'sd15 << FRAC_BITS);

    localparam logic [AMPW-1:0] AMP_ONE = AMPW'(16384);
    localparam logic [AMPW-1:0] AMP_CAP = AMPW'(64'd1 << 30);
    localparam logic [PW-1:0]   AMP_RND = PW'(8192);

    localparam logic [CNTW-1:0]  OCT_RESET     = CNTW'(3);
    localparam logic [PERSW-1:0] PERSIST_RESET = PERSW'(16384);

    // tuser codes
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    // configuration register indexes
    localparam logic CFG_OCTAVES = 1'b0;
    localparam logic CFG_PERSIST = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SETUP,
        S_HASH,
        S_GRAD,
        S_LERP,
        S_ACC,
        S_DCHK,
        S_DIV,
        S_OUT
    } t_state;

    // a*b / 2^FRAC_BITS, rounded to nearest, ties away from zero
    function automatic t_val rnd_q(input t_prod p);
        logic [PW-1:0] mag;
        logic [PW-1:0] sh;
        mag = p[PW-1] ? PW'(-p) : PW'(p);
        sh  = (mag + (PW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
        return p[PW-1] ? -$signed(sh[DW-1:0]) : $signed(sh[DW-1:0]);
    endfunction

    function automatic t_val grad(input logic [HASHW-1:0] h, input t_val x,
                                  input t_val y, input t_val z);
        t_val r;
        case (h)
            4'h0:    r = x + y;
            4'h1:    r = -x + y;
            4'h2:    r = x - y;
            4'h3:    r = -x - y;
            4'h4:    r = x + z;
            4'h5:    r = -x + z;
            4'h6:    r = x - z;
            4'h7:    r = -x - z;
            4'h8:    r = y + z;
            4'h9:    r = -y + z;
            4'hA:    r = y - z;
            4'hB:    r = -y - z;
            4'hC:    r = y + x;
            4'hD:    r = -y + z;
            4'hE:    r = y - x;
            default: r = -y - z;
        endcase
        return r;
    endfunction

endpackage

// ----- rtl/core/ognz_div.sv -----
// ----------------------------------------------------------------------------
// ognz_div
// Restoring divider, one quotient bit per cycle, with overflow flag.
// ----------------------------------------------------------------------------
module ognz_div #(
    parameter int NUM_W = 62,
    parameter int DEN_W = 35,
    parameter int Q_W   = 18
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic             o_sat,
    output logic [Q_W-1:0]   o_quot
);

    localparam int DV_W  = DEN_W + Q_W - 1;
    localparam int CMP_W = ((NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W) + 1;
    localparam int CNT_W = $clog2(Q_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0] r_rem;
    logic [DV_W-1:0]  r_div;
    logic [Q_W-1:0]   r_quot;
    logic             r_sat;
    logic             sat_hit;
    logic             ge;

    // quotient would not fit in Q_W bits
    assign sat_hit = CMP_W'(i_num) >= (CMP_W'(i_den) << Q_W);
    assign ge      = CMP_W'(r_rem) >= CMP_W'(r_div);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                if (sat_hit) begin
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                    r_cnt  <= CNT_W'(Q_W);
                end
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_sat  <= sat_hit;
            r_quot <= '0;
            r_rem  <= i_num;
            r_div  <= DV_W'(i_den) << (Q_W - 1);
        end else if (r_busy) begin
            if (ge) begin
                r_rem <= r_rem - NUM_W'(r_div);
            end
            r_quot <= {r_quot[Q_W-2:0], ge};
            r_div  <= r_div >> 1;
        end
    end

    assign o_done = r_done;
    assign o_sat  = r_sat;
    assign o_quot = r_quot;

endmodule

// ----- rtl/core/octave_gradient_noise_3d.sv -----
// ----------------------------------------------------------------------------
// octave_gradient_noise_3d
// Fractal sum of 3D improved gradient noise over a loadable permutation table.
// ----------------------------------------------------------------------------
// Items with tuser = load write one permutation table entry and complete
// with no result; load all 256 entries before the first sample.
// A sample runs each octave through one shared datapath: a setup step, a
// hash phase in which the 14 hash lookups on the single table read port
// overlap the 12 fade multiplies, a gradient step, the lerps and the
// weighting, all on one multiplier. The final normalising division is
// skipped for a sum that is not positive. No new item is taken until a
// sample is through; its result sits in an output register, so the next
// item is taken while it waits to be collected.
module octave_gradient_noise_3d
    import ognz_pkg::*;
#(
    parameter int MAX_OCTAVES = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // table_index, table_value, coord_x, coord_y, coord_z
    input  logic [IN_TDATA_W-1:0] i_s_axis_tdata,
    // operation
    input  logic [0:0]            i_s_axis_tuser,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // noise_value
    output logic [OUTW-1:0]       o_m_axis_tdata,
    input  logic                  i_cfg_we,
    input  logic [0:0]            i_cfg_index,
    input  logic [PERSW-1:0]      i_cfg_wdata
);

    localparam int OW    = $clog2(MAX_OCTAVES + 1);
    localparam int TW    = PW + OW;
    localparam int AW    = AMPW + OW;
    localparam int QB    = FRAC_BITS + 2;
    localparam int RW    = QB + OUTW + 1;
    localparam int STEPW = 5;
    localparam logic [STEPW-1:0] HASH_LAST = STEPW'(23);
    localparam logic [STEPW-1:0] LERP_LAST = STEPW'(13);
    localparam logic [STEPW-1:0] ACC_LAST  = STEPW'(2);

    t_state r_state, n_state;

    logic [CNTW-1:0]  r_oct_cnt;
    logic [PERSW-1:0] r_persist;

    logic [CELLW-1:0] r_perm [256];
    logic [CELLW-1:0] r_rd_data;
    logic [CELLW-1:0] rd_addr;

    logic [COORDW-1:0] r_x, r_y, r_z;
    logic [OW-1:0]     r_oct, r_noct;
    logic [STEPW-1:0]  r_step;

    logic [CELLW-1:0] r_cell [3];
    t_val             r_frac [3];
    t_val             r_fade [3];
    t_val             r_inner, r_t2, r_t3;
    logic [CELLW-1:0] r_a, r_b, r_aa, r_ab, r_ba, r_bb;
    logic [HASHW-1:0] r_h [8];
    t_val             r_g [8];
    t_val             r_l [6];
    t_val             r_noise;

    logic [AMPW-1:0]      r_amp;
    logic signed [TW-1:0] r_total;
    logic [AW-1:0]        r_amp_sum;
    t_prod                r_prod;

    logic            r_out_valid;
    logic [OUTW-1:0] r_out_data;
    logic [OUTW-1:0] r_res;

    logic accept, mem_we, div_start, out_load;
    logic div_done, div_sat;
    logic [QB-1:0] div_quot;

    logic [COORDW-1:0] sh_x, sh_y, sh_z;
    logic [3:0]        fk;
    logic [1:0]        fax;
    logic [1:0]        fsub;
    t_val              ft;
    logic [2:0]        lj;
    t_val              lo, hi, lt;
    t_val              rnd;
    t_val              mul_a;
    logic signed [MBW-1:0] mul_b;
    logic [2:0]        hidx;
    logic [PW-1:0]     amp_raw;
    logic [RW-1:0]     res_wide;
    logic [OUTW-1:0]   res_val;
    logic              last_oct;

    assign accept = i_s_axis_tvalid && o_s_axis_tready;

    // ---------------- state machine ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= (n_state != r_state) ? '0 : r_step + STEPW'(1);
        end
    end

    assign last_oct = (r_oct + OW'(1)) == r_noct;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept && i_s_axis_tuser[0] == OP_SAMPLE) n_state = S_SETUP;
            end
            S_SETUP: n_state = S_HASH;
            S_HASH: begin
                if (r_step == HASH_LAST) n_state = S_GRAD;
            end
            S_GRAD: n_state = S_LERP;
            S_LERP: begin
                if (r_step == LERP_LAST) n_state = S_ACC;
            end
            S_ACC: begin
                if (r_step == ACC_LAST) n_state = last_oct ? S_DCHK : S_SETUP;
            end
            S_DCHK: n_state = (r_total <= 0) ? S_OUT : S_DIV;
            S_DIV: begin
                if (div_done) n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || i_m_axis_tready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_s_axis_tready = 1'b0;
        mem_we          = 1'b0;
        div_start       = 1'b0;
        out_load        = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_s_axis_tready = 1'b1;
                mem_we          = accept && (i_s_axis_tuser[0] == OP_LOAD);
            end
            S_DCHK:  div_start = (r_total > 0);
            S_OUT:   out_load  = !r_out_valid || i_m_axis_tready;
            default: ;
        endcase
    end

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oct_cnt <= OCT_RESET;
            r_persist <= PERSIST_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index[0])
                CFG_OCTAVES: r_oct_cnt <= i_cfg_wdata[CNTW-1:0];
                CFG_PERSIST: r_persist <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // ---------------- permutation table ----------------
    always_comb begin
        case (r_step)
            5'd0:    rd_addr = r_cell[0];
            5'd1:    rd_addr = r_cell[0] + CELLW'(1);
            5'd2:    rd_addr = r_a;
            5'd3:    rd_addr = r_a + CELLW'(1);
            5'd4:    rd_addr = r_b;
            5'd5:    rd_addr = r_b + CELLW'(1);
            5'd6:    rd_addr = r_aa;
            5'd7:    rd_addr = r_ab;
            5'd8:    rd_addr = r_ba;
            5'd9:    rd_addr = r_bb;
            5'd10:   rd_addr = r_aa + CELLW'(1);
            5'd11:   rd_addr = r_ab + CELLW'(1);
            5'd12:   rd_addr = r_ba + CELLW'(1);
            5'd13:   rd_addr = r_bb + CELLW'(1);
            default: rd_addr = r_cell[0];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_perm[i_s_axis_tdata[CELLW-1:0]] <= i_s_axis_tdata[2*CELLW-1:CELLW];
        end
        r_rd_data <= r_perm[rd_addr];
    end

    // ---------------- datapath selects ----------------
    assign sh_x = r_x << r_oct;
    assign sh_y = r_y << r_oct;
    assign sh_z = r_z << r_oct;

    assign fk   = r_step[4:1];
    assign fax  = fk[3:2];
    assign fsub = fk[1:0];
    assign ft   = r_frac[fax];
    assign lj   = r_step[3:1];
    assign hidx = 3'(r_step - STEPW'(7));
    assign rnd  = rnd_q(r_prod);

    always_comb begin
        case (lj)
            3'd0:    begin lo = r_g[0]; hi = r_g[2]; end
            3'd1:    begin lo = r_g[1]; hi = r_g[3]; end
            3'd2:    begin lo = r_g[4]; hi = r_g[6]; end
            3'd3:    begin lo = r_g[5]; hi = r_g[7]; end
            3'd4:    begin lo = r_l[0]; hi = r_l[1]; end
            3'd5:    begin lo = r_l[2]; hi = r_l[3]; end
            default: begin lo = r_l[4]; hi = r_l[5]; end
        endcase
        if (lj < 3'd4) begin
            lt = r_fade[0];
        end else if (lj < 3'd6) begin
            lt = r_fade[1];
        end else begin
            lt = r_fade[2];
        end
    end

    always_comb begin
        mul_a = ft;
        mul_b = MBW'(ft);
        case (r_state)
            S_HASH: begin
                case (fsub)
                    2'd0:    begin mul_a = ft;   mul_b = MBW'(ft * t_val'(6) - FIFTEEN_Q); end
                    2'd1:    begin mul_a = ft;   mul_b = MBW'(ft); end
                    2'd2:    begin mul_a = r_t2; mul_b = MBW'(ft); end
                    default: begin mul_a = r_t3; mul_b = MBW'(r_inner); end
                endcase
            end
            S_LERP: begin
                mul_a = lt;
                mul_b = MBW'(hi - lo);
            end
            S_ACC: begin
                if (r_step == STEPW'(0)) begin
                    mul_a = r_noise + ONE_Q;
                end else begin
                    mul_a = t_val'(r_persist);
                end
                mul_b = MBW'({1'b0, r_amp});
            end
            default: ;
        endcase
    end

    assign amp_raw  = ($unsigned(r_prod) + AMP_RND) >> AMP_SHIFT;
    assign res_wide = (RW'({div_quot, OUTW'(0)}) + (RW'(1) << FRAC_BITS)) >> (FRAC_BITS + 1);
    assign res_val  = (div_sat || res_wide > RW'({OUTW{1'b1}})) ? {OUTW{1'b1}}
                                                                  : res_wide[OUTW-1:0];

    // ---------------- datapath registers ----------------
    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        case (r_state)
            S_IDLE: begin
                r_x       <= i_s_axis_tdata[2*CELLW +: COORDW];
                r_y       <= i_s_axis_tdata[2*CELLW+COORDW +: COORDW];
                r_z       <= i_s_axis_tdata[2*CELLW+2*COORDW +: COORDW];
                r_oct     <= '0;
                r_amp     <= AMP_ONE;
                r_total   <= '0;
                r_amp_sum <= '0;
                if (r_oct_cnt == '0) begin
                    r_noct <= OW'(1);
                end else if (int'(r_oct_cnt) > MAX_OCTAVES) begin
                    r_noct <= OW'(MAX_OCTAVES);
                end else begin
                    r_noct <= OW'(r_oct_cnt);
                end
            end
            S_SETUP: begin
                r_cell[0] <= sh_x[FRAC_BITS +: CELLW];
                r_cell[1] <= sh_y[FRAC_BITS +: CELLW];
                r_cell[2] <= sh_z[FRAC_BITS +: CELLW];
                r_frac[0] <= t_val'(sh_x[FRAC_BITS-1:0]);
                r_frac[1] <= t_val'(sh_y[FRAC_BITS-1:0]);
                r_frac[2] <= t_val'(sh_z[FRAC_BITS-1:0]);
            end
            S_HASH: begin
                // lookup data lands in the step after its address
                case (r_step)
                    5'd1:    r_a  <= r_rd_data + r_cell[1];
                    5'd2:    r_b  <= r_rd_data + r_cell[1];
                    5'd3:    r_aa <= r_rd_data + r_cell[2];
                    5'd4:    r_ab <= r_rd_data + r_cell[2];
                    5'd5:    r_ba <= r_rd_data + r_cell[2];
                    5'd6:    r_bb <= r_rd_data + r_cell[2];
                    5'd7, 5'd8, 5'd9, 5'd10, 5'd11, 5'd12, 5'd13, 5'd14:
                             r_h[hidx] <= r_rd_data[HASHW-1:0];
                    default: ;
                endcase
                if (r_step[0]) begin
                    case (fsub)
                        2'd0:    r_inner    <= rnd + TEN_Q;
                        2'd1:    r_t2       <= rnd;
                        2'd2:    r_t3       <= rnd;
                        default: r_fade[fax] <= rnd;
                    endcase
                end
            end
            S_GRAD: begin
                for (int c = 0; c < 8; c++) begin
                    r_g[c] <= grad(r_h[c],
                                   c[1] ? r_frac[0] - ONE_Q : r_frac[0],
                                   c[0] ? r_frac[1] - ONE_Q : r_frac[1],
                                   c[2] ? r_frac[2] - ONE_Q : r_frac[2]);
                end
            end
            S_LERP: begin
                if (r_step[0]) begin
                    if (lj == 3'd6) begin
                        r_noise <= lo + rnd;
                    end else begin
                        r_l[lj] <= lo + rnd;
                    end
                end
            end
            S_ACC: begin
                if (r_step == STEPW'(1)) begin
                    r_total   <= r_total + TW'(r_prod);
                    r_amp_sum <= r_amp_sum + AW'(r_amp);
                end else if (r_step == ACC_LAST) begin
                    r_amp <= (amp_raw > PW'(AMP_CAP)) ? AMP_CAP : amp_raw[AMPW-1:0];
                    r_oct <= r_oct + OW'(1);
                end
            end
            S_DCHK: r_res <= '0;
            S_DIV: begin
                if (div_done) r_res <= res_val;
            end
            default: ;
        endcase
    end

    ognz_div #(
        .NUM_W (TW),
        .DEN_W (AW),
        .Q_W   (QB)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   ($unsigned(r_total) + TW'(r_amp_sum >> 1)),
        .i_den   (r_amp_sum),
        .o_done  (div_done),
        .o_sat   (div_sat),
        .o_quot  (div_quot)
    );

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) r_out_data <= r_res;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

endmodule

// ----- rtl/core/ognz_chk.sv -----
// ----------------------------------------------------------------------------
// ognz_chk
// Port-level checks for the octave gradient noise block.
// ----------------------------------------------------------------------------
`include "octave_gradient_noise_3d_macros.svh"

module ognz_chk
    import ognz_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_s_axis_tvalid,
    input logic                  o_s_axis_tready,
    input logic [0:0]            i_s_axis_tuser,
    input logic                  o_m_axis_tvalid,
    input logic                  i_m_axis_tready,
    input logic [OUTW-1:0]       o_m_axis_tdata
);

    `OGNZ_ASSERT_ALWAYS(a_rst_no_result, !i_rst_n |=> !o_m_axis_tvalid, "result after reset")
    `OGNZ_ASSERT(a_hold_valid, (o_m_axis_tvalid && !i_m_axis_tready) |=> o_m_axis_tvalid, "result dropped")
    `OGNZ_ASSERT(a_hold_data, (o_m_axis_tvalid && !i_m_axis_tready) |=> $stable(o_m_axis_tdata), "result changed while stalled")
    `OGNZ_ASSERT(a_load_silent, (i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tuser[0] == OP_LOAD && !o_m_axis_tvalid) |=> !o_m_axis_tvalid, "load produced a result")
    `OGNZ_ASSERT(a_sample_busy, (i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tuser[0] == OP_SAMPLE) |=> !o_s_axis_tready, "sample transaction not held off")

endmodule

bind octave_gradient_noise_3d ognz_chk u_ognz_chk (.*);
